// ----- rtl/core/cmc_pkg.sv -----
// shared types and codes of the column majority consensus block
`timescale 1ns / 1ps
`default_nettype none
package cmc_pkg;

	// command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// counter lanes within one column entry
	localparam logic [2:0] LANE_A = 3'd0;
	localparam logic [2:0] LANE_C = 3'd1;
	localparam logic [2:0] LANE_G = 3'd2;
	localparam logic [2:0] LANE_T = 3'd3;
	localparam logic [2:0] LANE_N = 3'd4;
	localparam int         LANES  = 5;

	// one memory operation issued by the sequencer
	typedef struct packed {
		logic       load;   // increment one counter of the column
		logic       drain;  // vote and clear the column
		logic [2:0] lane;   // counter to increment on a load
		logic       last;   // final column of the group on a drain
		logic       trunc;  // a base of the group fell past the limit
	} cmc_op_t;

endpackage
`default_nettype wire

// ----- rtl/core/cmc_seq.sv -----
// column position sequencer: load, longest-read and drain positions
`timescale 1ns / 1ps
`default_nettype none
module cmc_seq
	import cmc_pkg::*;
#(
	parameter int MAX_COLUMNS = 256,
	parameter int AW          = 8,
	parameter int PW          = 9
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic          command,
	input  wire logic [2:0]    base_code,
	input  wire logic          read_ends,
	output logic               issue,
	output cmc_op_t            op,
	output logic [AW-1:0]      addr
);

	localparam logic [PW-1:0] LIMIT = PW'(MAX_COLUMNS);

	logic [PW-1:0] load_pos_q, longest_q, drain_pos_q;
	logic          overflow_q;
	logic [PW-1:0] load_nxt, drain_nxt;
	logic          load_fits, drain_ok, drain_last;

	assign load_fits  = load_pos_q < LIMIT;
	assign load_nxt   = load_pos_q + PW'(1);
	assign drain_ok   = drain_pos_q < longest_q;
	assign drain_nxt  = drain_pos_q + PW'(1);
	assign drain_last = drain_nxt >= longest_q;

	always_comb begin
		issue    = 1'b0;
		op       = '0;
		addr     = '0;
		if (command == CMD_LOAD) begin
			op.load = load_fits;
			op.lane = (base_code > LANE_N) ? LANE_N : base_code;
			addr    = load_pos_q[AW-1:0];
			issue   = accept && load_fits;
		end else begin
			op.drain = drain_ok;
			op.last  = drain_last;
			op.trunc = overflow_q;
			addr     = drain_pos_q[AW-1:0];
			issue    = accept && drain_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q  <= '0;
			longest_q   <= '0;
			drain_pos_q <= '0;
			overflow_q  <= 1'b0;
		end else if (accept) begin
			if (command == CMD_LOAD) begin
				if (load_fits) begin
					if (load_nxt > longest_q) begin
						longest_q <= load_nxt;
					end
				end else begin
					overflow_q <= 1'b1;
				end
				if (read_ends) begin
					load_pos_q <= '0;
				end else if (load_fits) begin
					load_pos_q <= load_nxt;
				end
			end else if (drain_ok) begin
				if (drain_last) begin
					longest_q   <= '0;
					drain_pos_q <= '0;
					overflow_q  <= 1'b0;
				end else begin
					drain_pos_q <= drain_nxt;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/cmc_rmw.sv -----
// column counter memory with clearing pass, read-modify-write and vote
`timescale 1ns / 1ps
`default_nettype none
module cmc_rmw
	import cmc_pkg::*;
#(
	parameter int MAX_COLUMNS = 256,
	parameter int COUNT_BITS  = 8,
	parameter int AW          = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          issue,
	input  wire cmc_op_t       op,
	input  wire logic [AW-1:0] addr,
	output logic               clearing,
	output logic               vote_valid,
	output logic [1:0]         vote_base,
	output logic [AW-1:0]      vote_addr,
	output logic               vote_last,
	output logic               vote_trunc
);

	localparam int              EW       = LANES * COUNT_BITS;
	localparam logic [AW-1:0]   LAST_ROW = AW'(MAX_COLUMNS - 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [EW-1:0] mem [MAX_COLUMNS];

	logic          clr_q;
	logic [AW-1:0] clr_addr_q;
	logic          vld_s1;
	cmc_op_t       op_s1;
	logic [AW-1:0] addr_s1;
	logic [EW-1:0] rd_s1;
	logic          fwd_v_q;
	logic [AW-1:0] fwd_addr_q;
	logic [EW-1:0] fwd_data_q;

	logic [EW-1:0]         cur, upd;
	logic                  we;
	logic [AW-1:0]         wa;
	logic [EW-1:0]         wd;
	logic [COUNT_BITS-1:0] cnt [LANES];
	logic [1:0]            best;

	// clearing pass after reset, one row a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == LAST_ROW) begin
				clr_q <= 1'b0;
			end
		end
	end

	assign clearing = clr_q;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			vld_s1  <= issue;
			fwd_v_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			op_s1   <= op;
			addr_s1 <= addr;
		end
		fwd_addr_q <= addr_s1;
		fwd_data_q <= upd;
	end

	// synchronous memory, one write and one read port
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1 <= mem[addr];
		end
		if (we) begin
			mem[wa] <= wd;
		end
	end

	// write of the previous cycle is not yet in the read data
	assign cur = (fwd_v_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_s1;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			cnt[k] = cur[k*COUNT_BITS +: COUNT_BITS];
		end
	end

	always_comb begin
		upd = '0;
		if (op_s1.load) begin
			upd = cur;
			for (int k = 0; k < LANES; k++) begin
				if (op_s1.lane == 3'(k) && cnt[k] != CNT_MAX) begin
					upd[k*COUNT_BITS +: COUNT_BITS] = cnt[k] + COUNT_BITS'(1);
				end
			end
		end
	end

	// majority of A, C, G, T; strict compare keeps the lower code on ties
	always_comb begin
		best = LANE_A[1:0];
		for (int k = 1; k < 4; k++) begin
			if (cnt[k] > cnt[best]) begin
				best = 2'(k);
			end
		end
	end

	always_comb begin
		if (clr_q) begin
			we = 1'b1;
			wa = clr_addr_q;
			wd = '0;
		end else begin
			we = vld_s1;
			wa = addr_s1;
			wd = upd;
		end
	end

	assign vote_valid = vld_s1 && op_s1.drain;
	assign vote_base  = best;
	assign vote_addr  = addr_s1;
	assign vote_last  = op_s1.last;
	assign vote_trunc = op_s1.trunc;

endmodule
`default_nettype wire

// ----- rtl/core/dna_column_majority_consensus.sv -----
// top level of the column majority consensus block
`timescale 1ns / 1ps
`default_nettype none
// column majority consensus: a transaction is taken when start is high and busy
// is low, one per cycle with no gaps needed. a load transaction counts one base
// into the counters of its column, or drops it past the limit, and gives no
// result; a drain transaction gives the consensus of the next column left on the
// result ports via the stage 1 and result registers, marked by done for exactly
// one cycle, and clears it. the receiver cannot stall, so every done cycle must
// be captured. after reset busy stays high while the counter memory is swept to
// zero one row a cycle; after that it stays low. the rate of one transaction per
// cycle comes from the counter memory with one read and one write port, read when
// a transaction is taken and written back the next cycle, with the write of the
// previous cycle forwarded when the same column is hit back to back
module dna_column_majority_consensus
	import cmc_pkg::*;
#(
	parameter int MAX_COLUMNS = 256,
	parameter int COUNT_BITS  = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic       command,
	input  wire logic [2:0] base_code,
	input  wire logic       read_ends,
	output logic            done,
	output logic [1:0]      consensus_base,
	output logic [7:0]      column,
	output logic            last_column,
	output logic            truncated
);

	// column address and position widths, a position can equal the limit
	localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int PW = $clog2(MAX_COLUMNS + 1);

	logic          accept;
	logic          issue;
	cmc_op_t       op;
	logic [AW-1:0] addr;
	logic          clearing;
	logic          vote_valid;
	logic [1:0]    vote_base;
	logic [AW-1:0] vote_addr;
	logic          vote_last;
	logic          vote_trunc;

	logic          done_q;
	logic [1:0]    base_q;
	logic [7:0]    column_q;
	logic          last_q;
	logic          trunc_q;

	// no transaction while the memory is being swept
	assign busy   = clearing;
	assign accept = start && !clearing;

	// position bookkeeping, decides which column each transaction touches
	cmc_seq #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.AW         (AW),
		.PW         (PW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.command  (command),
		.base_code(base_code),
		.read_ends(read_ends),
		.issue    (issue),
		.op       (op),
		.addr     (addr)
	);

	// counter memory, update and vote
	cmc_rmw #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.COUNT_BITS (COUNT_BITS),
		.AW         (AW)
	) u_rmw (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.op        (op),
		.addr      (addr),
		.clearing  (clearing),
		.vote_valid(vote_valid),
		.vote_base (vote_base),
		.vote_addr (vote_addr),
		.vote_last (vote_last),
		.vote_trunc(vote_trunc)
	);

	// result register, done is a one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vote_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (vote_valid) begin
			base_q   <= vote_base;
			column_q <= 8'(vote_addr);
			last_q   <= vote_last;
			trunc_q  <= vote_trunc;
		end
	end

	assign done           = done_q;
	assign consensus_base = base_q;
	assign column         = column_q;
	assign last_column    = last_q;
	assign truncated      = trunc_q;

endmodule
`default_nettype wire

// ----- rtl/core/cmc_checker.sv -----
// port checker of the column majority consensus block and its bind
`timescale 1ns / 1ps
`default_nettype none
module cmc_checker
	import cmc_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       command,
	input wire logic       done,
	input wire logic [7:0] column,
	input wire logic       last_column,
	input wire logic       truncated
);

	// a result comes only from an earlier accepted drain transaction
	a_done_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && command == CMD_DRAIN, 2))
		else $error("result without a drain transaction");

	// columns of one group come out in order
	a_column_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done) && !$past(last_column) |-> column == $past(column) + 8'd1)
		else $error("column index skipped");

	// a new group starts at column zero
	a_group_start: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done) && $past(last_column) |-> column == 8'd0)
		else $error("group did not restart at column zero");

	// the truncation flag cannot clear inside a group
	a_trunc_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done) && !$past(last_column) && $past(truncated) |-> truncated)
		else $error("truncation flag dropped within a group");

endmodule

bind dna_column_majority_consensus cmc_checker u_cmc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.command    (command),
	.done       (done),
	.column     (column),
	.last_column(last_column),
	.truncated  (truncated)
);
`default_nettype wire

// ----- test/tb_top.sv -----
// self-checking testbench of the column majority consensus block
`timescale 1ns / 1ps
module tb_top;
	import cmc_pkg::*;

	localparam int MAX_COLUMNS = 256;
	localparam int COUNT_BITS  = 8;
	localparam int ITEMS       = 1750;
	localparam int LIMIT_CYCLES = 60000;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// one transaction as it goes onto the command ports
	typedef struct {
		logic       command;
		logic [2:0] base_code;
		logic       read_ends;
	} base_op_t;

	// one consensus column as the block should report it
	typedef struct {
		logic [1:0] consensus_base;
		logic [7:0] column;
		logic       last_column;
		logic       truncated;
	} vote_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       command = CMD_LOAD;
	logic [2:0] base_code = 3'd0;
	logic       read_ends = 1'b0;
	logic       busy;
	logic       done;
	logic [1:0] consensus_base;
	logic [7:0] column;
	logic       last_column;
	logic       truncated;

	base_op_t pending_ops[$];
	vote_t    awaited_votes[$];
	int       total_ops;
	int       accepted_ops = 0;
	int       mismatches = 0;
	int       cycles = 0;

	// mirror of the block's column counters and group bookkeeping
	logic [COUNT_BITS-1:0] tally [MAX_COLUMNS][LANES];
	int unsigned load_pos;
	int unsigned longest;
	int unsigned drain_pos;
	bit          overflow;

	dna_column_majority_consensus #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.COUNT_BITS (COUNT_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.base_code     (base_code),
		.read_ends     (read_ends),
		.done          (done),
		.consensus_base(consensus_base),
		.column        (column),
		.last_column   (last_column),
		.truncated     (truncated)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// predictor: one accepted transaction updates the mirror and, for a
	// drain with a column left, queues the consensus that must come out
	// ---------------------------------------------------------------
	task automatic apply_to_tally(input base_op_t op);
		int unsigned lane;
		int unsigned col;
		int unsigned best;
		vote_t v;
		if (op.command == CMD_LOAD) begin
			// codes above n all land in the n counter
			lane = (op.base_code > LANE_N) ? LANE_N : op.base_code;
			if (load_pos < MAX_COLUMNS) begin
				if (tally[load_pos][lane] != COUNT_MAX)
					tally[load_pos][lane]++;
				load_pos++;
				if (load_pos > longest)
					longest = load_pos;
			end else begin
				// past the column limit: base is dropped, group is flagged
				overflow = 1'b1;
			end
			if (op.read_ends)
				load_pos = 0;
		end else if (drain_pos < longest) begin
			col = drain_pos;
			// strict greater-than keeps ties on the lower code, n never votes
			best = LANE_A;
			for (int k = LANE_C; k <= LANE_T; k++)
				if (tally[col][k] > tally[col][best])
					best = k;
			v.consensus_base = best[1:0];
			v.column         = col[7:0];
			v.last_column    = (col + 1 >= longest);
			v.truncated      = overflow;
			awaited_votes.push_back(v);
			for (int k = 0; k < LANES; k++)
				tally[col][k] = '0;
			if (v.last_column) begin
				// group closes; load position is left alone on purpose
				longest   = 0;
				drain_pos = 0;
				overflow  = 1'b0;
			end else begin
				drain_pos = col + 1;
			end
		end
		// a drain with nothing left changes nothing
	endtask

	// ---------------------------------------------------------------
	// stimulus building blocks
	// ---------------------------------------------------------------
	task automatic queue_op(input logic cmd, input logic [2:0] code, input logic ends);
		base_op_t op;
		op.command   = cmd;
		op.base_code = code;
		op.read_ends = ends;
		pending_ops.push_back(op);
	endtask

	// mostly the group's leaning base so columns have a clear majority,
	// sometimes any of a/c/g/t, now and then n or an out-of-range code
	function automatic logic [2:0] pick_code(input logic [2:0] lean);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return lean;
		else if (r < 85)
			return 3'($urandom_range(0, 3));
		else
			return 3'($urandom_range(4, 7));
	endfunction

	// one read of len bases; close=0 leaves the read open across the group
	task automatic queue_read(input int len, input logic [2:0] lean, input bit close);
		for (int i = 0; i < len; i++)
			queue_op(CMD_LOAD, pick_code(lean), close && (i == len - 1));
	endtask

	// drains with junk on the unused fields, optionally with short reads
	// slipped in between them
	task automatic queue_drains(input int n, input bit mix);
		for (int i = 0; i < n; i++) begin
			queue_op(CMD_DRAIN, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
			if (mix && $urandom_range(0, 99) < 6)
				queue_read($urandom_range(1, 3), 3'($urandom_range(0, 3)), 1'b1);
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
		mismatches++;
	endtask

	// ---------------------------------------------------------------
	// driver: holds a transaction until it is taken, idles at random
	// except during a stretch of back-to-back traffic in the middle of the run
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		base_op_t op;
		bit taken;
		bit idle;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				op.command   = command;
				op.base_code = base_code;
				op.read_ends = read_ends;
				apply_to_tally(op);
				accepted_ops++;
			end
			idle = ($urandom_range(0, 99) < 19) && !(accepted_ops >= 600 && accepted_ops < 1000);
			if (start && !taken) begin
				// transaction still waiting on busy, keep it on the ports
			end else if (pending_ops.size() != 0 && !idle) begin
				op = pending_ops.pop_front();
				command   <= op.command;
				base_code <= op.base_code;
				read_ends <= op.read_ends;
				start     <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: done marks a result for one cycle, no back-pressure
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		vote_t want;
		if (arst_n && done) begin
			if (awaited_votes.size() == 0) begin
				report_mismatch("unexpected result, column", column, -1);
			end else begin
				want = awaited_votes.pop_front();
				if (consensus_base !== want.consensus_base)
					report_mismatch("consensus_base", consensus_base, want.consensus_base);
				if (column !== want.column)
					report_mismatch("column", column, want.column);
				if (last_column !== want.last_column)
					report_mismatch("last_column", last_column, want.last_column);
				if (truncated !== want.truncated)
					report_mismatch("truncated", truncated, want.truncated);
			end
		end
	end

	// watchdog covers the reset sweep plus all traffic many times over
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("dna_column_majority_consensus verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus and end of run
	// ---------------------------------------------------------------
	initial begin
		int group;
		int nreads;
		int len;
		int maxlen;
		int ndrain;
		logic [2:0] lean;
		logic [2:0] low_code;
		logic [2:0] high_code;

		for (int c = 0; c < MAX_COLUMNS; c++)
			for (int k = 0; k < LANES; k++)
				tally[c][k] = '0;
		load_pos  = 0;
		longest   = 0;
		drain_pos = 0;
		overflow  = 1'b0;

		// directed: drains on an empty group, every base code, drains with
		// loads landing in columns already drained
		queue_op(CMD_DRAIN, 3'd0, 1'b0);
		queue_op(CMD_DRAIN, 3'd7, 1'b1);
		for (int c = 0; c < 8; c++)
			queue_op(CMD_LOAD, 3'(c), c == 7);
		queue_op(CMD_LOAD, LANE_T, 1'b0);
		queue_op(CMD_LOAD, LANE_T, 1'b0);
		queue_op(CMD_LOAD, LANE_G, 1'b0);
		queue_op(CMD_LOAD, LANE_C, 1'b1);
		queue_op(CMD_LOAD, 3'd7, 1'b1);
		queue_drains(3, 1'b0);
		queue_op(CMD_LOAD, LANE_G, 1'b0);
		queue_op(CMD_LOAD, LANE_G, 1'b1);
		queue_drains(6, 1'b0);

		// random groups; one reaches past the column limit, one saturates
		// two counters of column zero to check the tie at full count
		group = 0;
		while (pending_ops.size() < ITEMS) begin
			group++;
			lean = 3'($urandom_range(0, 3));
			if (group == 4) begin
				queue_read(MAX_COLUMNS + $urandom_range(1, 12), lean, 1'b1);
				queue_read($urandom_range(1, 4), lean, 1'b1);
				queue_drains(MAX_COLUMNS + 1, 1'b1);
			end else if (group == 12) begin
				low_code  = 3'($urandom_range(0, 2));
				high_code = 3'($urandom_range(low_code + 1, 3));
				for (int i = 0; i < 2 * int'(COUNT_MAX) + 10; i++)
					queue_op(CMD_LOAD, (i % 2) ? high_code : low_code, 1'b1);
				queue_drains(2, 1'b0);
			end else begin
				nreads = $urandom_range(1, 5);
				maxlen = 0;
				for (int r = 0; r < nreads; r++) begin
					len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10)
						: $urandom_range(11, 40);
					if (len > maxlen)
						maxlen = len;
					// now and then a read is left open into the next group
					queue_read(len, lean, $urandom_range(0, 99) >= 8);
				end
				ndrain = maxlen + $urandom_range(0, 2);
				if ($urandom_range(0, 99) < 20)
					ndrain = $urandom_range(0, maxlen);
				queue_drains(ndrain, 1'b1);
			end
		end
		total_ops = pending_ops.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_ops < total_ops)
			@(posedge clk);
		while (awaited_votes.size() != 0)
			@(posedge clk);
		// leave room for stray results after the last expected one
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("dna_column_majority_consensus verification clean");
		else
			$display("dna_column_majority_consensus verification failed");
		$finish;
	end

endmodule

// ----- dna_column_majority_consensus.f -----
rtl/core/cmc_pkg.sv
rtl/core/cmc_seq.sv
rtl/core/cmc_rmw.sv
rtl/core/dna_column_majority_consensus.sv
rtl/core/cmc_checker.sv
test/tb_top.sv
